@@ hdl/lfp_pkg.sv @@
// shared types, constants and codes for the led frame payload parser
package lfp_pkg;

  localparam int MAX_FRAMES      = 128;
  localparam int FRAME_BYTES     = 512;
  localparam int PALETTE_ENTRIES = 256;

  localparam logic [2:0] NUM_ENABLES = 3'd7;
  localparam logic [7:0] PALETTE_ON  = 8'd1;

  // write kinds carried on the result word
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_ENABLE  = 3'd1;
  localparam logic [2:0] KIND_PALETTE = 3'd2;
  localparam logic [2:0] KIND_LENGTH  = 3'd3;
  localparam logic [2:0] KIND_DATA    = 3'd4;

  typedef enum logic [2:0] {
    PH_ENABLES = 3'd0,
    PH_CCOUNT  = 3'd1,
    PH_COLOUR  = 3'd2,
    PH_FCOUNT  = 3'd3,
    PH_LENHI   = 3'd4,
    PH_LENLO   = 3'd5,
    PH_DATA    = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       end_of_write;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  write_kind;
    logic [7:0]  write_index;
    logic [8:0]  write_offset;
    logic [23:0] write_value;
    logic        overflow_flag;
    logic        truncated_flag;
    logic        data_fresh;
  } out_word_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  field_cnt;
    logic [7:0]  colours_left;
    logic [7:0]  palette_slot;
    logic [15:0] partial_colour;
    logic [7:0]  frames_left;
    logic [7:0]  frame_number;
    logic [7:0]  length_high;
    logic [15:0] bytes_left;
    logic [15:0] data_position;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:          PH_ENABLES,
    field_cnt:      3'd0,
    colours_left:   8'd0,
    palette_slot:   8'd0,
    partial_colour: 16'd0,
    frames_left:    8'd0,
    frame_number:   8'd0,
    length_high:    8'd0,
    bytes_left:     16'd0,
    data_position:  16'd0
  };

endpackage

@@ hdl/lfp_step.sv @@
// one parse step: current state and one byte give the next state and the result word
module lfp_step (
  input  lfp_pkg::parse_state_t state_cur,
  input  lfp_pkg::in_word_t     item,
  output lfp_pkg::parse_state_t state_nxt,
  output lfp_pkg::out_word_t    result
);

  lfp_pkg::parse_state_t st;
  lfp_pkg::out_word_t    res;
  logic [7:0]  b;
  logic [2:0]  fc_inc;
  logic [15:0] len;
  logic [7:0]  frames_dec;
  logic [15:0] bytes_dec;
  logic        frame_ovf;

  always_comb begin
    b          = item.payload_byte;
    st         = state_cur;
    res        = '0;
    fc_inc     = state_cur.field_cnt + 3'd1;
    len        = {state_cur.length_high, b};
    frames_dec = state_cur.frames_left - 8'd1;
    bytes_dec  = state_cur.bytes_left - 16'd1;
    frame_ovf  = ({1'b0, state_cur.frame_number} >= 9'(lfp_pkg::MAX_FRAMES));

    unique case (state_cur.phase)
      lfp_pkg::PH_ENABLES: begin
        res.write_kind  = lfp_pkg::KIND_ENABLE;
        res.write_index = {5'd0, state_cur.field_cnt};
        res.write_value = {16'd0, b};
        st.field_cnt    = fc_inc;
        if (fc_inc >= lfp_pkg::NUM_ENABLES) begin
          st.field_cnt = 3'd0;
          st.phase     = (b == lfp_pkg::PALETTE_ON) ? lfp_pkg::PH_CCOUNT : lfp_pkg::PH_DONE;
        end
      end
      lfp_pkg::PH_CCOUNT: begin
        st.colours_left   = b;
        st.palette_slot   = 8'd0;
        st.field_cnt      = 3'd0;
        st.partial_colour = 16'd0;
        st.phase          = (b == 8'd0) ? lfp_pkg::PH_FCOUNT : lfp_pkg::PH_COLOUR;
      end
      lfp_pkg::PH_COLOUR: begin
        if (state_cur.field_cnt < 3'd2) begin
          st.partial_colour = {state_cur.partial_colour[7:0], b};
          st.field_cnt      = fc_inc;
        end else begin
          res.write_kind    = lfp_pkg::KIND_PALETTE;
          res.write_index   = state_cur.palette_slot;
          res.write_value   = {state_cur.partial_colour, b};
          res.overflow_flag = ({1'b0, state_cur.palette_slot} >=
                               9'(lfp_pkg::PALETTE_ENTRIES));
          st.palette_slot   = state_cur.palette_slot + 8'd1;
          st.colours_left   = state_cur.colours_left - 8'd1;
          st.field_cnt      = 3'd0;
          st.partial_colour = 16'd0;
          if (st.colours_left == 8'd0) begin
            st.phase = lfp_pkg::PH_FCOUNT;
          end
        end
      end
      lfp_pkg::PH_FCOUNT: begin
        st.frames_left  = b;
        st.frame_number = 8'd0;
        st.phase        = (b == 8'd0) ? lfp_pkg::PH_DONE : lfp_pkg::PH_LENHI;
      end
      lfp_pkg::PH_LENHI: begin
        st.length_high = b;
        st.phase       = lfp_pkg::PH_LENLO;
      end
      lfp_pkg::PH_LENLO: begin
        res.write_kind    = lfp_pkg::KIND_LENGTH;
        res.write_index   = state_cur.frame_number;
        res.write_value   = {8'd0, len};
        res.overflow_flag = frame_ovf;
        st.bytes_left     = len;
        st.data_position  = 16'd0;
        if (len == 16'd0) begin
          st.frame_number = state_cur.frame_number + 8'd1;
          st.frames_left  = frames_dec;
          st.phase        = (frames_dec == 8'd0) ? lfp_pkg::PH_DONE : lfp_pkg::PH_LENHI;
        end else begin
          st.phase = lfp_pkg::PH_DATA;
        end
      end
      lfp_pkg::PH_DATA: begin
        res.write_kind    = lfp_pkg::KIND_DATA;
        res.write_index   = state_cur.frame_number;
        res.write_offset  = state_cur.data_position[8:0];
        res.write_value   = {16'd0, b};
        res.overflow_flag = frame_ovf ||
                            ({1'b0, state_cur.data_position} >= 17'(lfp_pkg::FRAME_BYTES));
        st.data_position  = state_cur.data_position + 16'd1;
        st.bytes_left     = bytes_dec;
        if (bytes_dec == 16'd0) begin
          st.frame_number = state_cur.frame_number + 8'd1;
          st.frames_left  = frames_dec;
          st.phase        = (frames_dec == 8'd0) ? lfp_pkg::PH_DONE : lfp_pkg::PH_LENHI;
        end
      end
      lfp_pkg::PH_DONE: begin
        // extra bytes after a complete structure
      end
      default: begin
      end
    endcase

    if (item.end_of_write) begin
      res.truncated_flag = (st.phase != lfp_pkg::PH_DONE);
      res.data_fresh     = 1'b1;
      st                 = lfp_pkg::STATE_RESET;
    end

    state_nxt = st;
    result    = res;
  end

endmodule

@@ hdl/led_frame_payload_parser_unit.sv @@
// top level of the led frame payload parser: input register, parse step, result register
// an accepted word is held in the input register, then its parse step result is registered in the result register
// throughput: one word per cycle while out_ready is high, set by the single parse step between the two registers
// the result register and the input register stall together only when out_ready is low
// reset (rst_n low, synchronous) empties both registers and puts the parser in enables phase
module led_frame_payload_parser_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lfp_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lfp_pkg::out_word_t  out_data
);

  // input register: holds the accepted word until the parse step can retire it
  logic                  in_valid_r, in_valid_nxt;
  lfp_pkg::in_word_t     in_word_r, in_word_nxt;

  // parser state, updated when a word moves into the result register
  lfp_pkg::parse_state_t state_r, state_nxt;
  lfp_pkg::parse_state_t step_state;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  lfp_pkg::out_word_t    out_word_r, out_word_nxt;
  lfp_pkg::out_word_t    step_result;

  logic advance;

  lfp_step u_step (
    .state_cur (state_r),
    .item      (in_word_r),
    .state_nxt (step_state),
    .result    (step_result)
  );

  // the held word retires when the result register is empty or being drained
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_word_nxt   = in_word_r;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    // result word leaves
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // parse step commits its state and its result together
    if (advance) begin
      state_nxt     = step_state;
      out_word_nxt  = step_result;
      out_valid_nxt = 1'b1;
      in_valid_nxt  = 1'b0;
    end

    // new word enters the input register
    if (in_valid && in_ready) begin
      in_word_nxt  = in_data;
      in_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= lfp_pkg::STATE_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    in_word_r  <= in_word_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule
